/* rtl/core/sortpq_pkg.sv */
package sortpq_pkg;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        logic [31:0] prio;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

endpackage

/* rtl/core/sortpq_cell.sv */
module sortpq_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sortpq_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]            new_value,
    input  logic [31:0]            new_priority,
    input  logic                   prev_at_after,
    input  sortpq_pkg::entry_t     prev_entry,
    input  sortpq_pkg::entry_t     next_entry,
    output sortpq_pkg::entry_t     entry,
    output sortpq_pkg::entry_t     entry_next,
    output logic                   at_after
);
    import sortpq_pkg::*;

    logic        valid_reg;
    logic [31:0] value_reg;
    logic [31:0] prio_reg;
    entry_t      entry_cur;
    entry_t      entry_next_w;

    assign entry_cur = {valid_reg, value_reg, prio_reg};

    // A cell is at or after the insertion point when it is empty or its
    // priority is not below the new one; the flag rises once along the row.
    assign at_after = !valid_reg ||
                      ($signed(prio_reg) >= $signed(new_priority));

    always_comb
    begin
        entry_next_w = entry_cur;
        if (ctrl.push)
        begin
            if (prev_at_after)
            begin
                entry_next_w = prev_entry;
            end
            else if (at_after)
            begin
                entry_next_w.valid = 1'b1;
                entry_next_w.value = new_value;
                entry_next_w.prio  = new_priority;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next_w = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next_w.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= entry_next_w.value;
        prio_reg  <= entry_next_w.prio;
    end

    assign entry      = entry_cur;
    assign entry_next = entry_next_w;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: op; tdata: item_value, item_priority
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: popped_value, head_value,
//                                         head_valid, entry_count
//
// Each request is finished in the cycle it is accepted: every cell compares its
// priority with the new one in parallel and shifts or loads locally, so one
// request per cycle is taken unless the output stalls. The result sits in an
// output register; a request is accepted whenever it is empty or being drained.
// Reset empties the queue at once; stored values need no clearing.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // item_value[31:0], item_priority[63:32]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // popped_value[31:0], head_value[63:32],
                                   // head_valid[64], entry_count[69:65], zero
    output logic [1:0]  m_tuser    // status
);
    import sortpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > 5) ? CW : 5;

    entry_t     cell_entry [CAPACITY];
    entry_t     cell_next  [CAPACITY];
    logic       cell_after [CAPACITY];
    cell_ctrl_t ctrl;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic [71:0]   out_data_reg;
    logic [1:0]    out_user_reg;
    logic          accept;
    logic          full;
    logic          empty;
    status_t       status;
    logic [31:0]   popped;
    logic [EW-1:0] count_ext;
    logic [71:0]   out_data_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign empty    = !cell_entry[0].valid;
    assign full     = cell_entry[CAPACITY-1].valid;

    always_comb
    begin
        ctrl.push  = 1'b0;
        ctrl.pop   = 1'b0;
        status     = ST_OK;
        popped     = 32'd0;
        count_next = count_reg;
        if (accept)
        begin
            if (s_tuser == OP_POP)
            begin
                if (empty)
                begin
                    status = ST_POP_EMPTY;
                end
                else
                begin
                    ctrl.pop   = 1'b1;
                    popped     = cell_entry[0].value;
                    count_next = count_reg - CW'(1);
                end
            end
            else
            begin
                if (full)
                begin
                    status = ST_PUSH_FULL;
                end
                else
                begin
                    ctrl.push  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_a;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_a = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_a = cell_after[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_e = '0;
        end
        else
        begin : g_inner
            assign next_e = cell_entry[i+1];
        end

        sortpq_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .new_value     (s_tdata[31:0]),
            .new_priority  (s_tdata[63:32]),
            .prev_at_after (prev_a),
            .prev_entry    (prev_e),
            .next_entry    (next_e),
            .entry         (cell_entry[i]),
            .entry_next    (cell_next[i]),
            .at_after      (cell_after[i])
        );
    end

    assign count_ext = EW'(count_next);

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[31:0]  = popped;
        out_data_next[63:32] = cell_next[0].valid ? cell_next[0].value : 32'd0;
        out_data_next[64]    = cell_next[0].valid;
        out_data_next[69:65] = count_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_front: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) == cell_entry[0].valid)
        else $error("entry count disagrees with front cell");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_tuser == OP_POP) && (count_reg == '0)
        |=> (m_tuser == ST_POP_EMPTY) && (count_reg == '0))
        else $error("pop on empty queue not flagged");

    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_tuser == OP_PUSH) && (count_reg != CW'(CAPACITY))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not add one entry");

endmodule
